// ===== sv/b64c_pkg.sv =====
// b64c_pkg: types, codes and alphabet functions for the base64 stream codec
// depends on nothing; used by every module of the codec
package b64c_pkg;

  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam logic [7:0] PLUS_CHAR = 8'h2B;
  localparam logic [7:0] SLASH_CHAR = 8'h2F;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CHAR   = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // kind of group job handed from front to back
  localparam logic [1:0] JOB_ENC = 2'd0;
  localparam logic [1:0] JOB_DEC = 2'd1;
  localparam logic [1:0] JOB_LEN = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] error;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] bits;
    logic [2:0]  cnt;   // results to emit, 1..4
    logic [2:0]  keep;  // encode: positions at or above this are padding
    logic        last;
    logic        bad;
  } job_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

  // bit 6 set when the character is outside the alphabet
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [6:0] s;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = 7'(c - 8'h30 + 8'd52);
    end else if (c == PLUS_CHAR) begin
      s = 7'd62;
    end else if (c == SLASH_CHAR) begin
      s = 7'd63;
    end else begin
      s = 7'h40;
    end
    return s;
  endfunction

endpackage

// ===== sv/b64c_front.sv =====
// b64c_front: accepts items, holds the direction register and gathers groups
// depends on b64c_pkg; pushes one job per finished group into b64c_queue
module b64c_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_stall,
  input  b64c_pkg::in_item_t data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              queue_full,
  output logic              push,
  output b64c_pkg::job_t    push_job
);

  logic        direction;
  logic [23:0] group_bits;
  logic [1:0]  group_fill;
  logic [1:0]  pad_marks;
  logic        bad_char;

  logic [23:0] group_bits_next;
  logic [1:0]  group_fill_next;
  logic [1:0]  pad_marks_next;
  logic        bad_char_next;

  logic        accept;
  logic        complete;
  logic [6:0]  sext;
  logic [5:0]  s;
  logic        is_pad;
  logic        is_bad;

  assign cfg_ready  = 1'b1;
  assign data_stall = queue_full;
  assign accept     = data_valid && !data_stall;

  always_comb begin
    sext   = b64c_pkg::char_to_sextet(data.in_byte);
    is_pad = (data.in_byte == b64c_pkg::PAD_CHAR);
    is_bad = sext[6] && !is_pad;
    s      = (sext[6]) ? 6'd0 : sext[5:0];

    group_bits_next = group_bits;
    group_fill_next = group_fill;
    pad_marks_next  = pad_marks;
    bad_char_next   = bad_char;
    complete        = 1'b0;
    push_job        = '0;

    if (direction == b64c_pkg::DIR_ENCODE) begin
      unique case (group_fill)
        2'd0:    group_bits_next = group_bits | {data.in_byte, 16'h0000};
        2'd1:    group_bits_next = group_bits | {8'h00, data.in_byte, 8'h00};
        default: group_bits_next = group_bits | {16'h0000, data.in_byte};
      endcase
      complete        = (group_fill >= 2'd2) || data.in_last;
      group_fill_next = group_fill + 2'd1;
      push_job.kind   = b64c_pkg::JOB_ENC;
      push_job.bits   = group_bits_next;
      push_job.cnt    = 3'd4;
      push_job.keep   = 3'(group_fill) + 3'd2;
      push_job.last   = data.in_last;
      push_job.bad    = 1'b0;
    end else begin
      unique case (group_fill)
        2'd0:    group_bits_next = group_bits | {s, 18'h0};
        2'd1:    group_bits_next = group_bits | {6'h0, s, 12'h0};
        2'd2:    group_bits_next = group_bits | {12'h0, s, 6'h0};
        default: group_bits_next = group_bits | {18'h0, s};
      endcase
      if (is_pad && group_fill == 2'd2) pad_marks_next[0] = 1'b1;
      if (is_pad && group_fill == 2'd3) pad_marks_next[1] = 1'b1;
      bad_char_next   = bad_char | is_bad;
      group_fill_next = group_fill + 2'd1;
      complete        = (group_fill == 2'd3) || data.in_last;
      push_job.bits   = group_bits_next;
      push_job.last   = data.in_last;
      push_job.bad    = bad_char_next;
      push_job.keep   = 3'd0;
      if (group_fill != 2'd3) begin
        // short final group: one length error result
        push_job.kind = b64c_pkg::JOB_LEN;
        push_job.cnt  = 3'd1;
      end else begin
        push_job.kind = b64c_pkg::JOB_DEC;
        if (data.in_last) begin
          push_job.cnt = 3'd3 - 3'(pad_marks_next[0]) - 3'(pad_marks_next[1]);
        end else begin
          push_job.cnt = 3'd3;
        end
      end
    end
  end

  assign push = accept && complete;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= b64c_pkg::DIR_ENCODE;
      group_bits <= '0;
      group_fill <= '0;
      pad_marks  <= '0;
      bad_char   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      direction  <= cfg_data;
      group_bits <= '0;
      group_fill <= '0;
      pad_marks  <= '0;
      bad_char   <= 1'b0;
    end else if (accept) begin
      if (complete) begin
        group_bits <= '0;
        group_fill <= '0;
        pad_marks  <= '0;
        bad_char   <= 1'b0;
      end else begin
        group_bits <= group_bits_next;
        group_fill <= group_fill_next;
        pad_marks  <= pad_marks_next;
        bad_char   <= bad_char_next;
      end
    end
  end

endmodule

// ===== sv/b64c_queue.sv =====
// b64c_queue: short first-in first-out queue of group jobs
// depends on b64c_pkg; sits between b64c_front and b64c_back
module b64c_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b64c_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output b64c_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64c_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/b64c_back.sv =====
// b64c_back: walks the head job and emits one result per cycle while the output is not stalled
// depends on b64c_pkg; takes jobs from b64c_queue, drives the output register
module b64c_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  b64c_pkg::job_t     head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output b64c_pkg::out_item_t result
);

  logic [1:0]          pos;
  logic                emit;
  logic                done;
  logic [5:0]          sext;
  b64c_pkg::out_item_t item;

  assign emit = head_valid && (!result_valid || !result_stall);
  assign done = ({1'b0, pos} == head.cnt - 3'd1);
  assign pop  = emit && done;

  always_comb begin
    unique case (pos)
      2'd0:    sext = head.bits[23:18];
      2'd1:    sext = head.bits[17:12];
      2'd2:    sext = head.bits[11:6];
      default: sext = head.bits[5:0];
    endcase

    item.out_last = head.last && done;
    item.out_byte = 8'h00;
    item.error    = b64c_pkg::ERR_NONE;
    unique case (head.kind)
      b64c_pkg::JOB_ENC: begin
        item.out_byte = ({1'b0, pos} >= head.keep) ? b64c_pkg::PAD_CHAR
                                                   : b64c_pkg::sextet_to_char(sext);
      end
      b64c_pkg::JOB_DEC: begin
        unique case (pos)
          2'd0:    item.out_byte = head.bits[23:16];
          2'd1:    item.out_byte = head.bits[15:8];
          default: item.out_byte = head.bits[7:0];
        endcase
        item.error = head.bad ? b64c_pkg::ERR_CHAR : b64c_pkg::ERR_NONE;
      end
      b64c_pkg::JOB_LEN: begin
        item.error = b64c_pkg::ERR_LENGTH;
      end
      default: begin
        item.error = b64c_pkg::ERR_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pos          <= '0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
        pos          <= done ? 2'd0 : pos + 2'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/base64_stream_codec_top.sv =====
// base64_stream_codec_top: streaming base64 encoder / decoder
// depends on b64c_pkg, b64c_front, b64c_queue and b64c_back
//
//   channel   signals                           moves
//   data      data_valid, data_stall, data      one byte or character request
//   result    result_valid, result_stall, result one character or byte
//   cfg       cfg_valid, cfg_ready, cfg_data    direction register write
//
// the back end emits one result per cycle while the output is not stalled;
// encoding makes four results per three bytes, so its input backs up into
// the queue; decoding takes one character per cycle when not stalled. a
// group's first result passes the job queue and then the output register.
// rst clears the direction (encode), the group state, queue and output stage.
// data_stall rises only when the job queue is full; result_stall holds the
// output register while the front keeps gathering.
module base64_stream_codec_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  b64c_pkg::in_item_t  data,
  output logic                result_valid,
  input  logic                result_stall,
  output b64c_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic           queue_full;
  logic           push;
  b64c_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  b64c_pkg::job_t head;

  b64c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data       (data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64c_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
